>>> sv/rbe_pkg.sv
`timescale 1ns / 1ps
package rbe_pkg;

  // sensor-frame vector, angle datapath and angle widths
  localparam int SW           = 40;
  localparam int CW           = 62;
  localparam int ZW           = 27;
  localparam int PRESCALE     = 20;
  localparam int ATAN_ENTRIES = 24;

  // pi/2 in units of 2^-24 rad
  localparam logic signed [ZW-1:0] HALF_PI = 27'sd26353589;

  typedef logic signed [SW-1:0] svec_t;
  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [ZW-1:0] angle_t;

  typedef struct packed {
    cvec_t  x;
    cvec_t  y;
    angle_t z;
  } cordic_st_t;

  // atan(2^-idx) in units of 2^-24 rad
  function automatic angle_t atan_units(input int idx);
    angle_t a;
    case (idx)
      0:  a = 27'sd13176795;
      1:  a = 27'sd7778716;
      2:  a = 27'sd4110060;
      3:  a = 27'sd2086331;
      4:  a = 27'sd1047214;
      5:  a = 27'sd524117;
      6:  a = 27'sd262123;
      7:  a = 27'sd131069;
      8:  a = 27'sd65536;
      9:  a = 27'sd32768;
      10: a = 27'sd16384;
      11: a = 27'sd8192;
      12: a = 27'sd4096;
      13: a = 27'sd2048;
      14: a = 27'sd1024;
      15: a = 27'sd512;
      16: a = 27'sd256;
      17: a = 27'sd128;
      18: a = 27'sd64;
      19: a = 27'sd32;
      20: a = 27'sd16;
      21: a = 27'sd8;
      22: a = 27'sd4;
      23: a = 27'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> sv/range_bearing_elevation.sv
`timescale 1ns / 1ps
// Throughput: one pose per cycle; the whole pipeline holds while a result
// waits in the output register and the output side is not ready.
// The planar root chain (37 cells) followed by the elevation CORDIC chain
// sets the latency. Reset clears the pinger registers and the valid chain.
module range_bearing_elevation #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // pose stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // sensor_x[31:0], sensor_y[63:32], sensor_z[95:64], quat_w[111:96],
  // quat_x[127:112], quat_y[143:128], quat_z[159:144]
  input  logic [159:0] in_tdata,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // range_out[33:0], bearing_out[49:34], elevation_out[64:50], zero pad
  output logic [71:0]  out_tdata
);

  import rbe_pkg::*;

  localparam logic [1:0] REG_PINGER_X = 2'd0;
  localparam logic [1:0] REG_PINGER_Y = 2'd1;
  localparam logic [1:0] REG_PINGER_Z = 2'd2;

  // stage bookkeeping: s at stage 4, squares summed at stage 7
  localparam int PLANAR_RW  = 37;
  localparam int RANGE_RW   = 34;
  localparam int SZ_LAG     = 3 + PLANAR_RW + 1;
  localparam int BEARING_LAG = SZ_LAG;
  localparam int RANGE_LAG  = ANGLE_ITERATIONS + 5;
  localparam int LAT        = 48 + ANGLE_ITERATIONS;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] pinger_r [3];
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) pinger_r[i] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_PINGER_X: pinger_r[0] <= cfg_pwdata;
        REG_PINGER_Y: pinger_r[1] <= cfg_pwdata;
        REG_PINGER_Z: pinger_r[2] <= cfg_pwdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PINGER_X: cfg_prdata = pinger_r[0];
      REG_PINGER_Y: cfg_prdata = pinger_r[1];
      REG_PINGER_Z: cfg_prdata = pinger_r[2];
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // flow control: one enable for every stage, the last stage is the
  // output register
  // ---------------------------------------------------------------------
  logic [LAT-1:0] vld_r, vld_nxt;
  logic           adv;

  assign adv       = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  // ---------------------------------------------------------------------
  // rounding helpers: round half up, then floor shift
  // ---------------------------------------------------------------------
  function automatic logic signed [18:0] rnd_m(input logic signed [34:0] v);
    logic signed [34:0] t;
    t = (v + 35'sd16384) >>> 15;
    return t[18:0];
  endfunction

  function automatic svec_t rnd_s(input logic signed [53:0] v);
    logic signed [53:0] t;
    t = (v + 54'sd16384) >>> 15;
    return t[SW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // stage 1: offset to the pinger, quaternion products
  // ---------------------------------------------------------------------
  logic signed [31:0] sensor [3];
  logic signed [15:0] qw, qx, qy, qz;

  assign sensor[0] = in_tdata[31:0];
  assign sensor[1] = in_tdata[63:32];
  assign sensor[2] = in_tdata[95:64];
  assign qw        = in_tdata[111:96];
  assign qx        = in_tdata[127:112];
  assign qy        = in_tdata[143:128];
  assign qz        = in_tdata[159:144];

  logic signed [32:0] d1_r [3];
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= {pinger_r[i][31], pinger_r[i]} - {sensor[i][31], sensor[i]};
      end
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xy_r <= qx * qy;
      wz_r <= qw * qz;
      xz_r <= qx * qz;
      wy_r <= qw * qy;
      yz_r <= qy * qz;
      wx_r <= qw * qx;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: rotation matrix in Q.15, row-major
  // ---------------------------------------------------------------------
  localparam logic signed [34:0] ONE_Q30 = 35'sd1 <<< 30;

  logic signed [18:0] m_r [9];
  logic signed [32:0] d2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= rnd_m(ONE_Q30 - ((35'(yy_r) + 35'(zz_r)) <<< 1));
      m_r[1] <= rnd_m((35'(xy_r) - 35'(wz_r)) <<< 1);
      m_r[2] <= rnd_m((35'(xz_r) + 35'(wy_r)) <<< 1);
      m_r[3] <= rnd_m((35'(xy_r) + 35'(wz_r)) <<< 1);
      m_r[4] <= rnd_m(ONE_Q30 - ((35'(xx_r) + 35'(zz_r)) <<< 1));
      m_r[5] <= rnd_m((35'(yz_r) - 35'(wx_r)) <<< 1);
      m_r[6] <= rnd_m((35'(xz_r) - 35'(wy_r)) <<< 1);
      m_r[7] <= rnd_m((35'(yz_r) + 35'(wx_r)) <<< 1);
      m_r[8] <= rnd_m(ONE_Q30 - ((35'(xx_r) + 35'(yy_r)) <<< 1));
      d2_r   <= d1_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: transpose products, row r scales offset component r
  // ---------------------------------------------------------------------
  logic signed [51:0] p_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[3*r+c] <= m_r[3*r+c] * d2_r[r];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: sensor-frame vector in Q.16
  // ---------------------------------------------------------------------
  svec_t s_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s_r[c] <= rnd_s(54'(p_r[c]) + 54'(p_r[3+c]) + 54'(p_r[6+c]));
      end
    end
  end

  // ---------------------------------------------------------------------
  // stages 5-7: squares from 19-bit halves, then the two sums
  // ---------------------------------------------------------------------
  svec_t       s_abs [3];
  logic [37:0] hh_r [3], hl_r [3], ll_r [3];
  logic [75:0] sq_r [3];
  logic [76:0] plane2_r;
  logic [77:0] total_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_abs[c] = s_r[c][SW-1] ? -s_r[c] : s_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        hh_r[c] <= s_abs[c][37:19] * s_abs[c][37:19];
        hl_r[c] <= s_abs[c][37:19] * s_abs[c][18:0];
        ll_r[c] <= s_abs[c][18:0] * s_abs[c][18:0];
        sq_r[c] <= (76'(hh_r[c]) << 38) + (76'(hl_r[c]) << 20) + 76'(ll_r[c]);
      end
      plane2_r <= 77'(sq_r[0]) + 77'(sq_r[1]);
      total_r  <= 78'(sq_r[0]) + 78'(sq_r[1]) + 78'(sq_r[2]);
    end
  end

  // ---------------------------------------------------------------------
  // root chains: planar length and range
  // ---------------------------------------------------------------------
  logic [PLANAR_RW-1:0] planar;
  logic [RANGE_RW-1:0]  range_root, range_d;

  rbe_sqrt #(.RW(PLANAR_RW), .IN_W(77)) u_planar (
    .clk (clk), .en (adv), .value_i (plane2_r), .root_o (planar)
  );

  rbe_sqrt #(.RW(RANGE_RW), .IN_W(78)) u_range (
    .clk (clk), .en (adv), .value_i (total_r), .root_o (range_root)
  );

  rbe_delay #(.WIDTH(RANGE_RW), .DEPTH(RANGE_LAG)) u_range_lag (
    .clk (clk), .en (adv), .din (range_root), .dout (range_d)
  );

  // ---------------------------------------------------------------------
  // angle chains: bearing straight from s, elevation once planar is known
  // ---------------------------------------------------------------------
  svec_t              sz_d, planar_s;
  logic signed [15:0] bearing, bearing_d, elevation;

  rbe_delay #(.WIDTH(SW), .DEPTH(SZ_LAG)) u_sz_lag (
    .clk (clk), .en (adv), .din (s_r[2]), .dout (sz_d)
  );

  assign planar_s = {{(SW-PLANAR_RW){1'b0}}, planar};

  rbe_cordic #(.ITER(ANGLE_ITERATIONS), .LIMIT(25736)) u_bearing (
    .clk (clk), .en (adv), .x_i (s_r[0]), .y_i (s_r[1]), .angle_o (bearing)
  );

  rbe_delay #(.WIDTH(16), .DEPTH(BEARING_LAG)) u_bearing_lag (
    .clk (clk), .en (adv), .din (bearing), .dout (bearing_d)
  );

  rbe_cordic #(.ITER(ANGLE_ITERATIONS), .LIMIT(12868)) u_elevation (
    .clk (clk), .en (adv), .x_i (planar_s), .y_i (sz_d), .angle_o (elevation)
  );

  // ---------------------------------------------------------------------
  // output register: holds the result until its transfer
  // ---------------------------------------------------------------------
  logic [RANGE_RW-1:0] range_out_r;
  logic [15:0]         bearing_out_r;
  logic [14:0]         elevation_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      range_out_r     <= range_d;
      bearing_out_r   <= bearing_d;
      elevation_out_r <= elevation[14:0];
    end
  end

  assign out_tdata = {7'b0, elevation_out_r, bearing_out_r, range_out_r};

endmodule

>>> sv/rbe_delay.sv
`timescale 1ns / 1ps
module rbe_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

>>> sv/rbe_sqrt_cell.sv
`timescale 1ns / 1ps
module rbe_sqrt_cell #(
  parameter int RW  = 34,
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rem_o,
  output logic [RW-1:0]   root_o
);

  localparam int IW = 2 * RW;
  localparam logic [RW-1:0] BIT_MASK = {{(RW-1){1'b0}}, 1'b1} << BIT;
  localparam logic [IW:0]   SQ_TERM  = {{IW{1'b0}}, 1'b1} << (2 * BIT);

  logic [IW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [IW:0]   trial;
  logic          take;

  // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
  always_comb begin
    trial    = ({{(RW+1){1'b0}}, root_i} << (BIT + 1)) + SQ_TERM;
    take     = {1'b0, rem_i} >= trial;
    rem_nxt  = take ? rem_i - trial[IW-1:0] : rem_i;
    root_nxt = take ? (root_i | BIT_MASK) : root_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

>>> sv/rbe_sqrt.sv
`timescale 1ns / 1ps
module rbe_sqrt #(
  parameter int RW   = 34,
  parameter int IN_W = 78
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] value_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rem  [RW+1];
  logic [RW-1:0]   root [RW+1];
  logic            sat, sat_d;
  logic [RW-1:0]   root_r;

  // any bit above the root's square range pins the root at all ones
  assign sat     = |value_i[IN_W-1:2*RW];
  assign rem[0]  = value_i[2*RW-1:0];
  assign root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    rbe_sqrt_cell #(.RW(RW), .BIT(RW - 1 - k)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem[k]),
      .root_i (root[k]),
      .rem_o  (rem[k+1]),
      .root_o (root[k+1])
    );
  end

  rbe_delay #(.WIDTH(1), .DEPTH(RW)) u_sat (
    .clk (clk), .en (en), .din (sat), .dout (sat_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= sat_d ? '1 : root[RW];
    end
  end

  assign root_o = root_r;

endmodule

>>> sv/rbe_cordic_cell.sv
`timescale 1ns / 1ps
module rbe_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  rbe_pkg::cordic_st_t st_i,
  output rbe_pkg::cordic_st_t st_o
);

  import rbe_pkg::*;

  localparam angle_t ATAN = atan_units(IDX);

  cordic_st_t st_r, st_nxt;
  cvec_t      dx, dy;

  always_comb begin
    dx = st_i.y >>> IDX;
    dy = st_i.x >>> IDX;
    // turn clockwise while y is not negative
    if (!st_i.y[CW-1]) begin
      st_nxt.x = st_i.x + dx;
      st_nxt.y = st_i.y - dy;
      st_nxt.z = st_i.z + ATAN;
    end else begin
      st_nxt.x = st_i.x - dx;
      st_nxt.y = st_i.y + dy;
      st_nxt.z = st_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

>>> sv/rbe_cordic.sv
`timescale 1ns / 1ps
module rbe_cordic #(
  parameter int ITER  = 16,
  parameter int LIMIT = 25736
) (
  input  logic               clk,
  input  logic               en,
  input  rbe_pkg::svec_t     x_i,
  input  rbe_pkg::svec_t     y_i,
  output logic signed [15:0] angle_o
);

  import rbe_pkg::*;

  localparam angle_t LIM      = angle_t'(LIMIT);
  localparam angle_t RND_HALF = angle_t'(1024);

  cordic_st_t pre_r, pre_nxt;
  cordic_st_t st [ITER+1];
  svec_t      px, py;
  logic       zero, zero_d;
  angle_t     zr;
  logic signed [15:0] angle_r, angle_nxt;

  // fold the left half-plane onto the right by a quarter turn
  always_comb begin
    zero      = (x_i == '0) && (y_i == '0);
    px        = x_i;
    py        = y_i;
    pre_nxt.z = '0;
    if (x_i[SW-1]) begin
      if (!y_i[SW-1]) begin
        px        = y_i;
        py        = -x_i;
        pre_nxt.z = HALF_PI;
      end else begin
        px        = -y_i;
        py        = x_i;
        pre_nxt.z = -HALF_PI;
      end
    end
    pre_nxt.x = {{(CW-SW-PRESCALE){px[SW-1]}}, px, {PRESCALE{1'b0}}};
    pre_nxt.y = {{(CW-SW-PRESCALE){py[SW-1]}}, py, {PRESCALE{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign st[0] = pre_r;

  for (genvar i = 0; i < ITER; i++) begin : g_cell
    rbe_cordic_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .st_i (st[i]),
      .st_o (st[i+1])
    );
  end

  rbe_delay #(.WIDTH(1), .DEPTH(ITER + 1)) u_zero (
    .clk (clk), .en (en), .din (zero), .dout (zero_d)
  );

  // round to Q2.13 and clamp the overshoot
  always_comb begin
    zr = (st[ITER].z + RND_HALF) >>> 11;
    if (zero_d) begin
      angle_nxt = '0;
    end else if (zr > LIM) begin
      angle_nxt = LIM[15:0];
    end else if (zr < -LIM) begin
      angle_nxt = -LIM[15:0];
    end else begin
      angle_nxt = zr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

>>> tb/sv/range_bearing_elevation_checker.sv
`timescale 1ns / 1ps
module range_bearing_elevation_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int ITERS = 16;
  localparam logic [3:0] ADDR_PX = 4'd0, ADDR_PY = 4'd4, ADDR_PZ = 4'd8;
  localparam longint RANGE_SAT = (64'd1 << 34) - 1;

  typedef struct {
    logic [33:0]        rng;
    logic signed [15:0] brg;
    logic signed [14:0] elev;
  } rbe_result_t;

  logic signed [31:0] pos_x, pos_y, pos_z;
  rbe_result_t result_q[$];

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rshr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] r, c;
    r = 0;
    for (int b = 36; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint atan_of(int i);
    longint tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return tab[i];
  endfunction

  // vectoring atan2 in 2^-24 rad
  function automatic longint vec_angle(longint x, longint y);
    longint a, t, dx, dy;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; a = 26353589;
      end else begin
        x = -y; y = t; a = -26353589;
      end
    end
    x = x <<< 20;
    y = y <<< 20;
    for (int i = 0; i < ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += atan_of(i);
      end else begin
        x -= dx; y += dy; a -= atan_of(i);
      end
    end
    return a;
  endfunction

  function automatic longint clampv(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic rbe_result_t predict_pose(logic [159:0] d);
    longint dx, dy, dz, w, x, y, z, one;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, sx, sy, sz;
    longint ax, ay, az, pl;
    logic [127:0] p2, rg;
    rbe_result_t r;
    dx = longint'(pos_x) - longint'($signed(d[31:0]));
    dy = longint'(pos_y) - longint'($signed(d[63:32]));
    dz = longint'(pos_z) - longint'($signed(d[95:64]));
    w = $signed(d[111:96]);  x = $signed(d[127:112]);
    y = $signed(d[143:128]); z = $signed(d[159:144]);
    one = 64'sd1 <<< 30;
    m00 = rshr(one - 2 * (y * y + z * z), 15);
    m01 = rshr(2 * (x * y - w * z), 15);
    m02 = rshr(2 * (x * z + w * y), 15);
    m10 = rshr(2 * (x * y + w * z), 15);
    m11 = rshr(one - 2 * (x * x + z * z), 15);
    m12 = rshr(2 * (y * z - w * x), 15);
    m20 = rshr(2 * (x * z - w * y), 15);
    m21 = rshr(2 * (y * z + w * x), 15);
    m22 = rshr(one - 2 * (x * x + y * y), 15);
    sx = rshr(m00 * dx + m10 * dy + m20 * dz, 15);
    sy = rshr(m01 * dx + m11 * dy + m21 * dz, 15);
    sz = rshr(m02 * dx + m12 * dy + m22 * dz, 15);
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    az = sz < 0 ? -sz : sz;
    p2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    pl = longint'(isqrt(p2));
    rg = isqrt(p2 + 128'(az) * 128'(az));
    r.rng = (rg > 128'(RANGE_SAT)) ? RANGE_SAT[33:0] : rg[33:0];
    r.brg = 16'(clampv(rshr(vec_angle(sx, sy), 11), 25736));
    r.elev = 15'(clampv(rshr(vec_angle(pl, sz), 11), 12868));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = result_q.size();

  always @(posedge clk) begin
    rbe_result_t e;
    if (!rst_n) begin
      pos_x <= 0; pos_y <= 0; pos_z <= 0;
      result_q.delete();
    end else begin
      // pose transfers see the registers as they stand before any write
      if (in_tvalid && in_tready) result_q.push_back(predict_pose(in_tdata));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_PX: pos_x <= cfg_pwdata;
          ADDR_PY: pos_y <= cfg_pwdata;
          ADDR_PZ: pos_z <= cfg_pwdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_tdata[33:0]), -1);
        end else begin
          e = result_q.pop_front();
          if (out_tdata[33:0] !== e.rng)
            report_mismatch("range", longint'(out_tdata[33:0]), longint'(e.rng));
          if (out_tdata[49:34] !== e.brg)
            report_mismatch("bearing", $signed(out_tdata[49:34]), e.brg);
          if (out_tdata[64:50] !== e.elev)
            report_mismatch("elevation", $signed(out_tdata[64:50]), e.elev);
        end
      end
    end
  end

endmodule

>>> tb/sv/range_bearing_elevation_tb.sv
`timescale 1ns / 1ps
module range_bearing_elevation_tb;

  localparam logic [3:0] ADDR_PX = 4'd0, ADDR_PY = 4'd4, ADDR_PZ = 4'd8;
  localparam int LATENCY = 64;

  logic         clk, rst_n;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid, in_tready;
  logic [159:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [71:0]  out_tdata;
  int           fail_count, pending;
  bit           stim_done;

  range_bearing_elevation u_top (.*);

  range_bearing_elevation_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // register write: setup then access; the caller releases the bus
  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
  endtask

  task automatic set_pinger(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    write_reg(ADDR_PX, px);
    write_reg(ADDR_PY, py);
    write_reg(ADDR_PZ, pz);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // drop valid, hold until the checker has every result, then let the pipe drain
  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // one pose transfer, with a random gap first unless told otherwise
  task automatic send_pose(logic [159:0] d, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [159:0] pack_pose(logic [31:0] sx, logic [31:0] sy,
      logic [31:0] sz, logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
      logic [15:0] qz);
    return {qz, qy, qx, qw, sz, sy, sx};
  endfunction

  // small offsets and quaternion parts within +/-23170 keep the angles meaningful; wild draws random bits
  function automatic logic [159:0] random_pose(bit wild);
    logic [31:0] s[3];
    logic [15:0] q[4];
    for (int i = 0; i < 3; i++)
      s[i] = wild ? $urandom() : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    for (int i = 0; i < 4; i++)
      q[i] = wild ? 16'($urandom()) : 16'($signed($urandom_range(0, 46340)) - 23170);
    return pack_pose(s[0], s[1], s[2], q[0], q[1], q[2], q[3]);
  endfunction

  // result side: random stalls, with calm stretches
  initial begin
    int stall;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stim_done || $urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 14);
      if (stall != 0) begin
        out_tready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] one_q;
    one_q = 16'h7FFF;
    stim_done = 0;
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_tvalid = 0; in_tdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset pinger, identity, zero vector, axes, full-scale inputs
    send_pose('0, 0);
    send_pose(pack_pose(0, 0, 0, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(32'hFFFF0000, 0, 0, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(32'h00010000, 0, 0, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(0, 32'h00010000, 0, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(0, 32'hFFFF0000, 0, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(0, 0, 32'hFFFF0000, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(0, 0, 32'h00010000, one_q, 0, 0, 0), 0);
    send_pose(pack_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
    send_pose(pack_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
    send_pose(pack_pose(32'h00010000, 32'h00010000, 0, 0, 0, 0, one_q), 0);
    send_pose(pack_pose(32'h00010000, 0, 32'h00010000, 0, one_q, 0, 0), 0);
    send_pose(pack_pose(32'h00010000, 0, 0, 0, 0, 0, 0), 0);
    drain();

    // extremes of the pinger against opposite sensor extremes
    set_pinger(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pose(pack_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        one_q, 0, 0, 0), 0);
    send_pose(pack_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        16'h8000, 0, 0, 0), 0);
    send_pose(pack_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        one_q, 0, 0, 0), 0);
    drain();
    set_pinger(32'h80000000, 32'h80000000, 32'h80000000);
    send_pose(pack_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        16'h5A82, 16'h5A82, 0, 0), 0);
    send_pose(random_pose(1), 0);
    drain();

    // random phases, each under a fresh pinger; back-to-back bursts included
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_pinger(32'h00000000, 32'h00000000, 32'h00000000);
      else
        set_pinger($urandom(), $urandom(), $urandom());
      for (int n = 0; n < 105; n++)
        send_pose(random_pose($urandom_range(0, 4) == 0), ph == 2);
      drain();
    end

    stim_done = 1;
    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rbe_pkg.sv
sv/rbe_delay.sv
sv/rbe_sqrt_cell.sv
sv/rbe_sqrt.sv
sv/rbe_cordic_cell.sv
sv/rbe_cordic.sv
sv/range_bearing_elevation.sv
tb/sv/range_bearing_elevation_checker.sv
tb/sv/range_bearing_elevation_tb.sv
